// File: design/bbe_pkg.sv
// Shared types, constants and helpers for the 3x3 box blur block.
// No dependencies; compile first.
package bbe_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int CHANNEL_COUNT = 3;
   localparam int ADDR_W        = $clog2(MAX_WIDTH);
   localparam int WIDTH_W       = 11;
   localparam int HEIGHT_W      = 16;
   localparam int PIX_W         = 8;
   localparam int SUM_W         = 12;
   localparam int CNT_W         = 4;
   localparam int RECIP_W       = 17;
   localparam int RECIP_SHIFT   = 16;
   localparam int PROD_W        = SUM_W + RECIP_W;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [CHANNEL_COUNT-1:0] rgb_type;

   typedef struct packed {
      rgb_type upper;
      rgb_type middle;
   } line_type;

   typedef struct packed {
      logic              valid;
      logic              emit;
      logic              pre;
      logic              top_ex;
      logic              bot_ex;
      logic              left_ex;
      logic              right_ex;
      logic              last;
      logic [ADDR_W-1:0] addr;
      rgb_type           pix;
   } beat_ctl_type;

   typedef struct packed {
      logic                               valid;
      logic                               last;
      logic [CNT_W-1:0]                   count;
      logic [CHANNEL_COUNT-1:0][SUM_W-1:0] sum;
   } sum_beat_type;

   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      case (count)
         4'd2:    m = RECIP_W'(32768);
         4'd3:    m = RECIP_W'(21846);
         4'd4:    m = RECIP_W'(16384);
         4'd6:    m = RECIP_W'(10923);
         4'd9:    m = RECIP_W'(7282);
         default: m = RECIP_W'(65536);
      endcase
      return m;
   endfunction

endpackage

// File: design/bbe_if.sv
// Valid/ready channel interfaces for pixel input and blurred pixel output.
// Depends on bbe_pkg.
interface bbe_req_if import bbe_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    mode;
   pix_type in_chan0;
   pix_type in_chan1;
   pix_type in_chan2;

   modport source (output valid, mode, in_chan0, in_chan1, in_chan2, input ready);
   modport sink   (input valid, mode, in_chan0, in_chan1, in_chan2, output ready);
endinterface

interface bbe_rsp_if import bbe_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type out_chan0;
   pix_type out_chan1;
   pix_type out_chan2;
   logic    frame_last;

   modport source (output valid, out_chan0, out_chan1, out_chan2, frame_last, input ready);
   modport sink   (input valid, out_chan0, out_chan1, out_chan2, frame_last, output ready);
endinterface

// File: design/bbe_window.sv
// Line buffer RAM, 3x3 window registers and neighbourhood sums.
// Depends on bbe_pkg.
module bbe_window import bbe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  beat_ctl_type beat_in,
   output sum_beat_type sum_out
);

   line_type          mem [MAX_WIDTH];
   line_type          rd_ff;
   beat_ctl_type      beat_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   line_type          fwd_data_ff;
   rgb_type           win_ff [3][3];
   sum_beat_type      sum_ff;

   line_type     line;
   line_type     wr_data;
   rgb_type      newcol [3];
   logic         row_on [3];
   logic [1:0]   rows;
   logic [1:0]   cols;
   sum_beat_type sum_in;

   always_comb begin
      line = (fwd_valid_ff && (fwd_addr_ff == beat_ff.addr)) ? fwd_data_ff : rd_ff;
      newcol[0] = line.upper;
      newcol[1] = line.middle;
      newcol[2] = beat_ff.pix;
      wr_data.upper  = line.middle;
      wr_data.middle = beat_ff.pix;

      row_on[0] = !beat_ff.top_ex;
      row_on[1] = 1'b1;
      row_on[2] = !beat_ff.bot_ex;
      rows = 2'd1 + 2'(!beat_ff.top_ex) + 2'(!beat_ff.bot_ex);
      cols = 2'd1 + 2'(!beat_ff.left_ex) + 2'(!beat_ff.pre && !beat_ff.right_ex);

      sum_in.valid = beat_ff.valid && beat_ff.emit;
      sum_in.last  = beat_ff.last;
      sum_in.count = CNT_W'(rows) * CNT_W'(cols);
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
         sum_in.sum[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            if (row_on[r]) begin
               sum_in.sum[ch] = sum_in.sum[ch] + SUM_W'(win_ff[r][2][ch]);
               if (!beat_ff.left_ex) begin
                  sum_in.sum[ch] = sum_in.sum[ch] + SUM_W'(win_ff[r][1][ch]);
               end
               if (!beat_ff.pre && !beat_ff.right_ex) begin
                  sum_in.sum[ch] = sum_in.sum[ch] + SUM_W'(newcol[r][ch]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && beat_in.valid) begin
         rd_ff <= mem[beat_in.addr];
      end
      if (adv && beat_ff.valid) begin
         mem[beat_ff.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
         sum_ff.valid  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (adv) begin
         beat_ff <= beat_in;
         sum_ff  <= sum_in;
         if (beat_ff.valid) begin
            fwd_valid_ff <= 1'b1;
            fwd_addr_ff  <= beat_ff.addr;
            fwd_data_ff  <= wr_data;
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
               win_ff[r][2] <= newcol[r];
            end
         end
      end
   end

   assign sum_out = sum_ff;

endmodule

// File: design/box_blur_3x3_edge_average_top.sv
// 3x3 box blur with edge averaging: control registers, position counters,
// divide stage and output register. Depends on bbe_pkg, bbe_if, bbe_window.
//
// Takes one beat per clock unless the output stalls, pixels or flushes, and
// gives each channel the truncated mean of its in-image 3x3 neighbourhood.
// A result leaves width+1 beats after its centre pixel; after the last
// pixel, width+1 flush beats drain the frame and the final result carries
// frame_last. The two previous rows sit in one 1024 x 48-bit RAM, read when
// a beat is taken and written back from beat_ff as the pipe advances,
// bypassed when consecutive beats hit the same column. A stalled output
// holds the whole pipe. A flush while the frame is still arriving is taken
// and dropped. Any register write restarts the frame; write only while idle.
module box_blur_3x3_edge_average_top import bbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bbe_req_if.sink               req_chan,
   bbe_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [WIDTH_W-1:0]  image_width_ff;
   logic [HEIGHT_W-1:0] image_height_ff;
   logic [HEIGHT_W:0]   in_row_ff;
   logic [ADDR_W-1:0]   in_col_ff;
   logic [HEIGHT_W-1:0] out_row_ff;
   logic [ADDR_W-1:0]   out_col_ff;
   logic [WIDTH_W-1:0]  lead_ff;
   logic                rsp_valid_ff;
   rgb_type             rsp_data_ff;
   logic                rsp_last_ff;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [WIDTH_W-1:0]  w_plus1;
   logic                adv;
   logic                acc;
   logic                csr_wr;
   reg_index_type       csr_idx;
   logic                frame_in;
   logic                wrap;
   logic                out_wrap;
   beat_ctl_type        beat;
   sum_beat_type        sum_beat;
   logic [PROD_W-1:0]   prod [CHANNEL_COUNT];
   rgb_type             quot;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (image_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      h_eff   = (image_height_ff == '0) ? HEIGHT_W'(1) : image_height_ff;
      w_plus1 = w_eff + WIDTH_W'(1);

      adv      = !rsp_valid_ff || rsp_chan.ready;
      acc      = req_chan.valid && adv;
      csr_wr   = csr_psel && csr_penable && csr_pwrite;
      csr_idx  = reg_index_type'(csr_paddr[2]);
      frame_in = in_row_ff < {1'b0, h_eff};
      wrap     = ({1'b0, in_col_ff} + WIDTH_W'(1)) >= w_eff;
      out_wrap = ({1'b0, out_col_ff} + WIDTH_W'(1)) >= w_eff;

      beat.valid    = acc && !(req_chan.mode && frame_in);
      beat.emit     = lead_ff >= w_plus1;
      beat.pre      = in_col_ff == '0;
      beat.top_ex   = out_row_ff == '0;
      beat.bot_ex   = out_row_ff >= (h_eff - HEIGHT_W'(1));
      beat.left_ex  = out_col_ff == '0;
      beat.right_ex = out_wrap;
      beat.last     = beat.bot_ex && out_wrap;
      beat.addr     = in_col_ff;
      beat.pix[0]   = frame_in ? req_chan.in_chan0 : '0;
      beat.pix[1]   = frame_in ? req_chan.in_chan1 : '0;
      beat.pix[2]   = frame_in ? req_chan.in_chan2 : '0;

      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
         prod[ch] = PROD_W'(sum_beat.sum[ch]) * PROD_W'(recip(sum_beat.count));
         quot[ch] = prod[ch][RECIP_SHIFT +: PIX_W];
      end
   end

   bbe_window u_window (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .beat_in (beat),
      .sum_out (sum_beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_W'(1024);
         image_height_ff <= HEIGHT_W'(1024);
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         lead_ff         <= '0;
      end else if (csr_wr) begin
         if (csr_idx == REG_IMAGE_WIDTH) begin
            image_width_ff <= csr_pwdata[WIDTH_W-1:0];
         end else begin
            image_height_ff <= csr_pwdata[HEIGHT_W-1:0];
         end
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         lead_ff    <= '0;
      end else if (beat.valid) begin
         if (beat.emit && beat.last) begin
            in_row_ff  <= '0;
            in_col_ff  <= '0;
            out_row_ff <= '0;
            out_col_ff <= '0;
            lead_ff    <= '0;
         end else begin
            if (wrap) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + (HEIGHT_W+1)'(1);
            end else begin
               in_col_ff <= in_col_ff + ADDR_W'(1);
            end
            if (lead_ff < w_plus1) begin
               lead_ff <= lead_ff + WIDTH_W'(1);
            end
            if (beat.emit) begin
               if (out_wrap) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + HEIGHT_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + ADDR_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sum_beat.valid;
         rsp_data_ff  <= quot;
         rsp_last_ff  <= sum_beat.last;
      end
   end

   always_comb begin
      req_chan.ready      = adv;
      rsp_chan.valid      = rsp_valid_ff;
      rsp_chan.out_chan0  = rsp_data_ff[0];
      rsp_chan.out_chan1  = rsp_data_ff[1];
      rsp_chan.out_chan2  = rsp_data_ff[2];
      rsp_chan.frame_last = rsp_last_ff;
      csr_pready          = 1'b1;
      if (csr_idx == REG_IMAGE_WIDTH) begin
         csr_prdata = CSR_DATA_W'(image_width_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(image_height_ff);
      end
   end

endmodule
